@@ hdl/kmer_table_match_counter_defines.svh @@
// ----------------------------------------------------------------------------
// kmer_table_match_counter_defines.svh
// Assertion macros for the k-mer table match counter.
// Empty bodies when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef KMER_TABLE_MATCH_COUNTER_DEFINES_SVH
`define KMER_TABLE_MATCH_COUNTER_DEFINES_SVH

`ifndef SYNTH

// Property checked outside reset
`define KTMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every edge, reset included
`define KTMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define KTMC_ASSERT(lbl, clk, rst_n, prop, msg)
`define KTMC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hdl/ktmc_pkg.sv @@
// ----------------------------------------------------------------------------
// ktmc_pkg
// Shared constants, command codes and control/status types of the
// k-mer table match counter.
// ----------------------------------------------------------------------------
package ktmc_pkg;

    localparam int KMER_LEN    = 21;
    localparam int TABLE_DEPTH = 256;
    localparam int COUNT_WIDTH = 32;

    localparam int KMER_BITS = 2 * KMER_LEN;
    localparam int IDX_W     = 8;
    localparam int LIM_W     = 9;
    localparam int SEEN_W    = $clog2(KMER_LEN + 1);
    localparam int HITS_W    = 10;
    localparam int CVAL_W    = 32;
    localparam int CMD_W     = 3;
    localparam int BASE_W    = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BASE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

    // highest plain base code; above it a base counts as A
    localparam logic [BASE_W-1:0] BASE_T = 3'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic scan_rd;    // read table entry at scan index
        logic scan_wr;    // compare, update count, step index
        logic out_load;   // move result into output register
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_needed;  // accepted item is a base that starts a scan
        logic scan_last;    // scan index is the last entry in use
        logic out_free;     // output register can take a result
    } dp_stat_t;

endpackage

@@ hdl/ktmc_ram.sv @@
// ----------------------------------------------------------------------------
// ktmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ktmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/ktmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ktmc_ctrl
// Sequencer: takes one item, runs the table scan for a full window,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module ktmc_ctrl
    import ktmc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.scan_needed ? ST_SCAN_RD : ST_FINISH;
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                state_next = stat.scan_last ? ST_FINISH : ST_SCAN_RD;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // commands
    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.accept   = s_ready && s_valid;
    assign cmd.scan_rd  = (state_reg == ST_SCAN_RD);
    assign cmd.scan_wr  = (state_reg == ST_SCAN_CMP);
    assign cmd.out_load = (state_reg == ST_FINISH) && stat.out_free;

endmodule

@@ hdl/ktmc_dpath.sv @@
// ----------------------------------------------------------------------------
// ktmc_dpath
// Windows, reference table, count store with valid bits, scan index,
// hit accumulator and the output register.
// ----------------------------------------------------------------------------
module ktmc_dpath
    import ktmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctl_cmd_t             cmd,
    output dp_stat_t             stat,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [BASE_W-1:0]    s_base,
    input  logic [IDX_W-1:0]     s_entry_index,
    input  logic [KMER_BITS-1:0] s_entry_kmer,
    input  logic                 cfg_wr_en,
    input  logic [LIM_W-1:0]     cfg_wr_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_window_valid,
    output logic [HITS_W-1:0]    m_hits,
    output logic [CVAL_W-1:0]    m_count_value
);

    logic [LIM_W-1:0]       entries_in_use_reg;
    logic [KMER_BITS-1:0]   fwd_reg, rev_reg;
    logic [SEEN_W-1:0]      seen_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [HITS_W-1:0]      hits_reg;
    logic                   wv_reg;
    logic [TABLE_DEPTH-1:0] cnt_vld_reg;
    logic                   rd_vld_reg;
    logic                   m_valid_reg;
    logic                   m_wv_reg;
    logic [HITS_W-1:0]      m_hits_reg;
    logic [CVAL_W-1:0]      m_cval_reg;

    logic [LIM_W-1:0]       lim;
    logic                   base_full;
    logic [1:0]             b;
    logic                   acc_base, acc_load, acc_count;
    logic                   cnt_re;
    logic [IDX_W-1:0]       cnt_raddr;
    logic [KMER_BITS-1:0]   kmer_rd;
    logic [COUNT_WIDTH-1:0] cnt_rd, cnt_eff, cnt_new;
    logic [COUNT_WIDTH:0]   cnt_sum;
    logic [1:0]             inc;
    logic [HITS_W:0]        hits_sum;
    logic [CVAL_W-1:0]      cval;

    // configuration and entry limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_in_use_reg <= '0;
        end else if (cfg_wr_en) begin
            entries_in_use_reg <= cfg_wr_data;
        end
    end

    assign lim = (entries_in_use_reg > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH)
                                                            : entries_in_use_reg;

    // decode of the accepted item
    assign acc_base  = cmd.accept && (s_cmd == CMD_BASE);
    assign acc_load  = cmd.accept && (s_cmd == CMD_LOAD) &&
                       ({1'b0, s_entry_index} < LIM_W'(TABLE_DEPTH));
    assign acc_count = cmd.accept && (s_cmd == CMD_COUNT);
    assign b         = (s_base <= BASE_T) ? s_base[1:0] : 2'd0;
    assign base_full = (seen_reg >= SEEN_W'(KMER_LEN - 1));

    // status
    assign stat.scan_needed = (s_cmd == CMD_BASE) && base_full && (lim != '0);
    assign stat.scan_last   = ((LIM_W'(idx_reg) + LIM_W'(1)) == lim);
    assign stat.out_free    = !m_valid_reg || m_ready;

    // windows and base counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg  <= '0;
            rev_reg  <= '0;
            seen_reg <= '0;
        end else if (cmd.accept && (s_cmd == CMD_START)) begin
            fwd_reg  <= '0;
            rev_reg  <= '0;
            seen_reg <= '0;
        end else if (acc_base) begin
            fwd_reg <= (fwd_reg << 2) | KMER_BITS'(b);
            rev_reg <= (rev_reg >> 2) | (KMER_BITS'(~b) << (KMER_BITS - 2));
            if (seen_reg < SEEN_W'(KMER_LEN)) begin
                seen_reg <= seen_reg + SEEN_W'(1);
            end
        end
    end

    // reference table
    ktmc_ram #(
        .WIDTH (KMER_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_kmer_ram (
        .aclk  (aclk),
        .we    (acc_load),
        .waddr (s_entry_index),
        .wdata (s_entry_kmer),
        .re    (cmd.scan_rd),
        .raddr (idx_reg),
        .rdata (kmer_rd)
    );

    // count store; the read port serves scans and count reads
    assign cnt_re    = cmd.scan_rd || acc_count;
    assign cnt_raddr = cmd.scan_rd ? idx_reg : s_entry_index;

    ktmc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_count_ram (
        .aclk  (aclk),
        .we    (cmd.scan_wr),
        .waddr (idx_reg),
        .wdata (cnt_new),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rd)
    );

    // valid bit per count: an entry not valid reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
        end else if (cmd.accept && (s_cmd == CMD_CLEAR)) begin
            cnt_vld_reg <= '0;
        end else if (acc_load) begin
            cnt_vld_reg[s_entry_index] <= 1'b0;
        end else if (cmd.scan_wr) begin
            cnt_vld_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_re) begin
            rd_vld_reg <= cnt_vld_reg[cnt_raddr];
        end
    end

    assign cnt_eff = rd_vld_reg ? cnt_rd : '0;

    // compare against both windows, saturating count update
    assign inc      = 2'(kmer_rd == fwd_reg) + 2'(kmer_rd == rev_reg);
    assign cnt_sum  = {1'b0, cnt_eff} + (COUNT_WIDTH + 1)'(inc);
    assign cnt_new  = cnt_sum[COUNT_WIDTH] ? '1 : cnt_sum[COUNT_WIDTH-1:0];
    assign hits_sum = {1'b0, hits_reg} + (HITS_W + 1)'(inc);

    // scan index, hit accumulator, item command
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg  <= s_cmd;
            wv_reg   <= acc_base && base_full;
            hits_reg <= '0;
            idx_reg  <= '0;
        end else if (cmd.scan_wr) begin
            hits_reg <= hits_sum[HITS_W] ? '1 : hits_sum[HITS_W-1:0];
            idx_reg  <= idx_reg + IDX_W'(1);
        end
    end

    assign cval = (cmd_reg == CMD_COUNT) ? CVAL_W'(cnt_eff) : '0;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_wv_reg   <= wv_reg;
            m_hits_reg <= hits_reg;
            m_cval_reg <= cval;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_window_valid = m_wv_reg;
    assign m_hits         = m_hits_reg;
    assign m_count_value  = m_cval_reg;

endmodule

@@ hdl/kmer_table_match_counter.sv @@
// Flow: the result of every item passes through the output register. A base that completes
//   a window scans the table entry by entry through one read port, over N entries,
//   N = min(entries_in_use, 256). No new item is taken until the last one is done, and a
//   result still held in the output register stalls input.
// Reset (aresetn low, synchronous): windows, base count, register and all counts cleared at once.
// Reference table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
// kmer_table_match_counter
// Counts occurrences of reference k-mers on both strands of a base stream.
// ----------------------------------------------------------------------------
`include "kmer_table_match_counter_defines.svh"

module kmer_table_match_counter
    import ktmc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [LIM_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [BASE_W-1:0]    s_base,
    input  logic [IDX_W-1:0]     s_entry_index,
    input  logic [KMER_BITS-1:0] s_entry_kmer,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_window_valid,
    output logic [HITS_W-1:0]    m_hits,
    output logic [CVAL_W-1:0]    m_count_value
);

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    ktmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (ctl_cmd)
    );

    ktmc_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (ctl_cmd),
        .stat           (dp_stat),
        .s_cmd          (s_cmd),
        .s_base         (s_base),
        .s_entry_index  (s_entry_index),
        .s_entry_kmer   (s_entry_kmer),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_valid (m_window_valid),
        .m_hits         (m_hits),
        .m_count_value  (m_count_value)
    );

    // checks
    `KTMC_ASSERT(a_hits_need_window, aclk, aresetn,
        m_valid && !m_window_valid |-> m_hits == '0, "hits without a full window")
    `KTMC_ASSERT(a_one_item_at_a_time, aclk, aresetn,
        s_valid && s_ready |=> !s_ready, "transfer taken while an item is in progress")
    `KTMC_ASSERT(a_scan_only_in_use, aclk, aresetn,
        ctl_cmd.scan_rd |-> !(ctl_cmd.accept || ctl_cmd.out_load),
        "scan overlaps transfer or result load")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-mer table match counter. Reference k-mers are
// cut from a random sequence, on both strands, and reads are streamed from the
// same sequence, so windows keep hitting table entries. A scoreboard class
// tracks the table, counts and windows, and checks every result in order.
// ----------------------------------------------------------------------------
import ktmc_pkg::*;

// command codes the block leaves unused
localparam logic [CMD_W-1:0]  CMD_SPARE_5 = 3'd5;
localparam logic [CMD_W-1:0]  CMD_SPARE_6 = 3'd6;
localparam logic [CMD_W-1:0]  CMD_SPARE_7 = 3'd7;
// N base, and the plain A code
localparam logic [BASE_W-1:0] BASE_N      = 3'd4;
localparam logic [1:0]        NUC_A       = 2'd0;
localparam int unsigned       HITS_MAX    = 1023;

typedef struct packed {
    logic              window_valid;
    logic [HITS_W-1:0] hits;
    logic [CVAL_W-1:0] count_value;
} tally_result_t;

// Mirror of the table, counters and windows; holds the expected results
class kmer_tally_board;
    logic [KMER_BITS-1:0]   ref_kmer [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] tally    [TABLE_DEPTH];
    logic [KMER_BITS-1:0]   fwd_win;
    logic [KMER_BITS-1:0]   rc_win;
    int unsigned            bases_in_win;
    int unsigned            in_use;
    tally_result_t          expected_tallies [$];
    int unsigned            mismatches;

    function new();
        foreach (ref_kmer[i]) begin
            ref_kmer[i] = '0;
            tally[i]    = '0;
        end
        fwd_win      = '0;
        rc_win       = '0;
        bases_in_win = 0;
        in_use       = 0;
        mismatches   = 0;
    endfunction

    // bump every in-use entry equal to the window; counters stick at the top
    function int unsigned tally_window(logic [KMER_BITS-1:0] win);
        int unsigned n;
        int unsigned lim;
        int          i;
        n   = 0;
        lim = (in_use < TABLE_DEPTH) ? in_use : TABLE_DEPTH;
        for (i = 0; i < lim; i++) begin
            if (ref_kmer[i] == win) begin
                if (tally[i] != '1)
                    tally[i] = tally[i] + COUNT_WIDTH'(1);
                n++;
            end
        end
        return n;
    endfunction

    // an accepted input transfer: update state, queue what must come out
    function void note_item(logic [CMD_W-1:0] cmd, logic [BASE_W-1:0] base,
                            logic [IDX_W-1:0] idx, logic [KMER_BITS-1:0] kmer);
        tally_result_t res;
        logic [1:0]    b;
        int unsigned   h;
        res = '0;
        case (cmd)
            CMD_LOAD: begin
                if (idx < TABLE_DEPTH) begin
                    ref_kmer[idx] = kmer;
                    tally[idx]    = '0;
                end
            end
            CMD_BASE: begin
                b       = (base > BASE_T) ? NUC_A : base[1:0];
                fwd_win = {fwd_win[KMER_BITS-3:0], b};
                rc_win  = {~b, rc_win[KMER_BITS-1:2]};
                if (bases_in_win < KMER_LEN)
                    bases_in_win++;
                if (bases_in_win >= KMER_LEN) begin
                    h = tally_window(fwd_win);
                    h += tally_window(rc_win);
                    res.window_valid = 1'b1;
                    res.hits = (h > HITS_MAX) ? HITS_W'(HITS_MAX) : HITS_W'(h);
                end
            end
            CMD_START: begin
                fwd_win      = '0;
                rc_win       = '0;
                bases_in_win = 0;
            end
            CMD_COUNT: begin
                if (idx < TABLE_DEPTH)
                    res.count_value = CVAL_W'(tally[idx]);
            end
            CMD_CLEAR: begin
                foreach (tally[i])
                    tally[i] = '0;
            end
            default: ;
        endcase
        expected_tallies = {expected_tallies, res};
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // an accepted result transfer, against the oldest expectation
    task check_result(logic wv, logic [HITS_W-1:0] hits, logic [CVAL_W-1:0] cval);
        tally_result_t want;
        if (expected_tallies.size() == 0) begin
            report_mismatch("result with nothing outstanding", 64'(cval), 64'(0));
            return;
        end
        want = expected_tallies.pop_front();
        if (wv !== want.window_valid)
            report_mismatch("window_valid", 64'(wv), 64'(want.window_valid));
        if (hits !== want.hits)
            report_mismatch("hits", 64'(hits), 64'(want.hits));
        if (cval !== want.count_value)
            report_mismatch("count_value", 64'(cval), 64'(want.count_value));
    endtask
endclass

module tb_top;

    localparam int          GENOME_LEN  = 600;
    localparam int unsigned TAIL_CYCLES = 2 * TABLE_DEPTH + 64;
    localparam int          N_PHASES    = 8;

    logic                 aclk;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [LIM_W-1:0]     cfg_wr_data    = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd          = '0;
    logic [BASE_W-1:0]    s_base         = '0;
    logic [IDX_W-1:0]     s_entry_index  = '0;
    logic [KMER_BITS-1:0] s_entry_kmer   = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic                 m_window_valid;
    logic [HITS_W-1:0]    m_hits;
    logic [CVAL_W-1:0]    m_count_value;

    kmer_tally_board board = new();

    logic [1:0]  genome [GENOME_LEN];
    bit          loaded [TABLE_DEPTH];
    int unsigned items_sent    = 0;
    int unsigned hold_off_req  = 0;
    bit          sender_steady = 1'b0;

    // entries in use per phase, and items to spend in each
    int unsigned phase_in_use [N_PHASES] = '{16, 1, 256, 511, 40, 0, 5, 24};
    int unsigned phase_budget [N_PHASES] = '{110, 60, 40, 30, 90, 40, 80, 80};

    kmer_table_match_counter i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_base         (s_base),
        .s_entry_index  (s_entry_index),
        .s_entry_kmer   (s_entry_kmer),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_valid (m_window_valid),
        .m_hits         (m_hits),
        .m_count_value  (m_count_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // watch both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_result(m_window_valid, m_hits, m_count_value);
            if (s_valid && s_ready)
                board.note_item(s_cmd, s_base, s_entry_index, s_entry_kmer);
        end
    end

    function automatic logic [BASE_W-1:0] rand_base();
        return BASE_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [IDX_W-1:0] rand_idx();
        return IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    endfunction

    function automatic logic [KMER_BITS-1:0] rand_kmer();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[KMER_BITS-1:0];
    endfunction

    // mostly an entry in use, sometimes anywhere in the table
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned lim;
        lim = (board.in_use < TABLE_DEPTH) ? board.in_use : TABLE_DEPTH;
        if (lim != 0 && $urandom_range(0, 3) != 0)
            return IDX_W'($urandom_range(0, lim - 1));
        return rand_idx();
    endfunction

    // k-mer cut from the sequence, forward or reverse complement
    function automatic logic [KMER_BITS-1:0] genome_kmer(int unsigned off, bit flip);
        logic [KMER_BITS-1:0] k;
        int unsigned          i;
        k = '0;
        for (i = 0; i < KMER_LEN; i++)
            k = {k[KMER_BITS-3:0], flip ? ~genome[off + KMER_LEN - 1 - i] : genome[off + i]};
        return k;
    endfunction

    // one input transfer, after a random gap
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BASE_W-1:0] base,
                             input logic [IDX_W-1:0] idx, input logic [KMER_BITS-1:0] kmer);
        int unsigned gap;
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sender_steady || r < 55)
            gap = 0;
        else if (r < 88)
            gap = $urandom_range(1, 3);
        else if (r < 97)
            gap = $urandom_range(4, 8);
        else
            gap = $urandom_range(15, 50);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_base        <= base;
        s_entry_index <= idx;
        s_entry_kmer  <= kmer;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] idx);
        logic [KMER_BITS-1:0] k;
        int unsigned          r;
        int unsigned          j;
        r = $urandom_range(0, 99);
        j = $urandom_range(0, TABLE_DEPTH - 1);
        if (r < 75)
            k = genome_kmer($urandom_range(0, GENOME_LEN - KMER_LEN), 1'($urandom_range(0, 1)));
        else if (r < 85 && loaded[j])
            k = board.ref_kmer[j];      // duplicate entry, hits more than once
        else if (r < 95)
            k = rand_kmer();
        else
            k = $urandom_range(0, 1) ? '1 : '0;
        send_item(CMD_LOAD, rand_base(), idx, k);
        loaded[idx] = 1'b1;
    endtask

    // make sure entries 0 .. upto-1 hold something before they come into use
    task automatic fill_table(input int unsigned upto);
        int unsigned i;
        for (i = 0; i < upto; i++)
            if (!loaded[i])
                load_entry(IDX_W'(i));
    endtask

    // a read taken from the sequence on either strand, with the odd error
    task automatic stream_read(input int unsigned len, input bit with_start);
        int unsigned       off;
        int unsigned       i;
        bit                flip;
        logic [1:0]        g;
        logic [BASE_W-1:0] code;
        if (with_start)
            send_item(CMD_START, rand_base(), rand_idx(), rand_kmer());
        off  = $urandom_range(0, GENOME_LEN - len);
        flip = 1'($urandom_range(0, 1));
        for (i = 0; i < len; i++) begin
            g    = flip ? ~genome[off + len - 1 - i] : genome[off + i];
            code = {1'b0, g};
            if ($urandom_range(0, 99) < 3)
                code = rand_base();
            else if (g == NUC_A && $urandom_range(0, 3) == 0)
                code = BASE_N + BASE_W'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 4)
                send_item(CMD_COUNT, rand_base(), pick_index(), rand_kmer());
            send_item(CMD_BASE, code, rand_idx(), rand_kmer());
        end
    endtask

    // sender rests until every outstanding result has been taken
    task automatic await_empty();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.expected_tallies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_in_use(input int unsigned n);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LIM_W'(n);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.in_use = n;
    endtask

    // random mix of reads, count reads, loads, clears, starts, loose bases and odd commands
    task automatic run_phase(input int unsigned budget);
        int unsigned       stop_at;
        int unsigned       r;
        logic [CMD_W-1:0]  spare;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            sender_steady = ($urandom_range(0, 7) == 0);
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if ($urandom_range(0, 9) == 0)
                    stream_read($urandom_range(1, KMER_LEN - 1), 1'b1);
                else
                    stream_read($urandom_range(KMER_LEN, KMER_LEN + 24),
                                $urandom_range(0, 9) != 0);
            end else if (r < 62) begin
                send_item(CMD_COUNT, rand_base(), pick_index(), rand_kmer());
            end else if (r < 70) begin
                load_entry(rand_idx());
            end else if (r < 74) begin
                send_item(CMD_CLEAR, rand_base(), rand_idx(), rand_kmer());
            end else if (r < 79) begin
                case ($urandom_range(0, 2))
                    0:       spare = CMD_SPARE_5;
                    1:       spare = CMD_SPARE_6;
                    default: spare = CMD_SPARE_7;
                endcase
                send_item(spare, rand_base(), rand_idx(), rand_kmer());
            end else if (r < 86) begin
                send_item(CMD_START, rand_base(), rand_idx(), rand_kmer());
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(CMD_BASE, rand_base(), rand_idx(), rand_kmer());
            end
        end
        sender_steady = 1'b0;
    endtask

    // result side: random stalls, steady stretches, and long hold-offs on request
    initial begin : result_sink
        int unsigned r;
        int unsigned n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_req != 0) begin
                n            = hold_off_req;
                hold_off_req = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(40, 150)) @(posedge aclk);
                end else if (r < 62) begin
                    m_ready <= 1'b1;
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                end else if (r < 94) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge aclk);
                end else begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge aclk);
                end
            end
        end
    end

    // main sequence
    initial begin : stimulus
        int unsigned i;
        int unsigned p;
        for (i = 0; i < GENOME_LEN; i++)
            genome[i] = 2'($urandom_range(0, 3));
        foreach (loaded[j])
            loaded[j] = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fresh counts, table extremes, every command, every base code
        send_item(CMD_COUNT, BASE_T, '0, '0);
        send_item(CMD_COUNT, '1, '1, '1);
        send_item(CMD_LOAD, '0, '0, '1);
        send_item(CMD_LOAD, '1, '1, '0);
        send_item(CMD_LOAD, BASE_T, IDX_W'(1), genome_kmer(0, 1'b0));
        loaded[0]               = 1'b1;
        loaded[1]               = 1'b1;
        loaded[TABLE_DEPTH - 1] = 1'b1;
        send_item(CMD_COUNT, '0, '0, '0);
        send_item(CMD_SPARE_5, '1, '1, '1);
        send_item(CMD_SPARE_6, '0, '0, '0);
        send_item(CMD_SPARE_7, '1, '0, '1);
        send_item(CMD_CLEAR, '0, '1, '0);
        send_item(CMD_START, '1, '0, '1);
        for (i = 0; i < 8; i++)
            send_item(CMD_BASE, BASE_W'(i), rand_idx(), rand_kmer());
        send_item(CMD_START, '0, '1, '0);

        // random phases, each under its own table size
        for (p = 0; p < N_PHASES; p++) begin
            fill_table((phase_in_use[p] < TABLE_DEPTH) ? phase_in_use[p] : TABLE_DEPTH);
            await_empty();
            set_in_use(phase_in_use[p]);
            if (p == 0) begin
                // output held off while a long read keeps coming
                hold_off_req = 300;
                stream_read(40, 1'b1);
            end
            run_phase(phase_budget[p]);
        end

        await_empty();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_tallies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
